// File: src/rmeul_pkg.sv
// Package for the rotation-matrix-to-Euler block: widths, CORDIC constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmeul_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_TABLE_LEN = 24;
  // CORDIC datapath: Q2.22 operands grow by the CORDIC gain, so 28 bits hold them
  localparam int XY_W = 28;
  localparam int Z_W = 28;
  localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam int SQ_W = 29;
  // one square-root step per stage, one result bit each
  localparam int SQRT_STEPS = 15;

  function automatic logic signed [Z_W-1:0] atan_q24(input int i);
    logic signed [Z_W-1:0] t;
    begin
      case (i)
        0: t = 28'sd13176795;
        1: t = 28'sd7778716;
        2: t = 28'sd4110060;
        3: t = 28'sd2086331;
        4: t = 28'sd1047214;
        5: t = 28'sd524117;
        6: t = 28'sd262123;
        7: t = 28'sd131069;
        default: t = (i < ATAN_TABLE_LEN) ? (28'sd1 <<< (24 - i)) : 28'sd0;
      endcase
      return t;
    end
  endfunction

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic zero;
  } cord_t;

  // convert a Q24 angle to Q3.13, round half up, saturate
  function automatic logic signed [15:0] to_q13(input logic signed [Z_W-1:0] z,
                                                input logic zero,
                                                input logic signed [15:0] lim);
    logic signed [Z_W-1:0] s;
    logic signed [Z_W-1:0] r;
    begin
      s = z + 28'sd1024;
      r = s >>> 11;
      if (zero) return 16'sd0;
      if (r > Z_W'(lim)) return lim;
      if (r < -Z_W'(lim)) return -lim;
      return r[15:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: src/rmeul_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rmeul_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] up_z;
  modport source (output valid, right_x, right_y, right_z, fwd_x, fwd_y, fwd_z, up_z,
                  input ready);
  modport sink (input valid, right_x, right_y, right_z, fwd_x, fwd_y, fwd_z, up_z,
                output ready);
endinterface

interface rmeul_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_x;
  logic signed [14:0] angle_y;
  logic signed [15:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface
`default_nettype wire

// File: src/rotation_matrix_to_euler_xyz.sv
// Top level: rotation matrix to XYZ Euler angles, fully pipelined CORDIC.
// Depends on rmeul_pkg and the channel interfaces in rmeul_if.sv.
`timescale 1ns / 1ps
`default_nettype none
// Takes one matrix word per cycle and returns one angle word per cycle while the
// output is not stalled. The pipe is an input register, fifteen bit-serial
// square-root stages for the asin cosine, a CORDIC setup stage, one stage per
// CORDIC iteration (three lanes side by side) and an output register. The whole
// pipe advances when the output register is empty or being read, so a stall
// holds every stage.
module rotation_matrix_to_euler_xyz
  import rmeul_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  rmeul_in_if.sink in_ch,
  rmeul_out_if.source out_ch
);
  localparam int NS = SQRT_STEPS + CORDIC_STEPS + 3;

  logic adv;
  logic [NS-1:0] vld_r;
  assign adv = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
    end
  end

  // stage arrays: index 0 is the input register, then one entry per sqrt stage
  logic [SQ_W-1:0] sq_n_r [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_res_r [SQRT_STEPS+1];
  logic signed [16:0] sa_y_r [SQRT_STEPS+1], sb_y_r [SQRT_STEPS+1];
  logic signed [15:0] sa_x_r [SQRT_STEPS+1];
  logic signed [15:0] sb_x_r [SQRT_STEPS+1], sr_z_r [SQRT_STEPS+1];
  logic [1:0] sg_r [SQRT_STEPS+1]; // [1] = +1, [0] = -1
  logic signed [31:0] rz_sq;
  assign rz_sq = in_ch.right_z * in_ch.right_z;

  // input register, gimbal decode, sqrt radicand 2^28 - rz^2
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n_r[0] <= (SQ_W'(1) << 28) - SQ_W'(rz_sq);
      sq_res_r[0] <= '0;
      sr_z_r[0] <= in_ch.right_z;
      sg_r[0] <= {in_ch.right_z >= ONE_Q14, in_ch.right_z <= -ONE_Q14};
      if (in_ch.right_z >= ONE_Q14 || in_ch.right_z <= -ONE_Q14) begin
        sa_y_r[0] <= 17'(in_ch.fwd_x);
        sa_x_r[0] <= in_ch.fwd_y;
      end else begin
        sa_y_r[0] <= -17'(in_ch.fwd_z);
        sa_x_r[0] <= in_ch.up_z;
      end
      sb_y_r[0] <= -17'(in_ch.right_y);
      sb_x_r[0] <= in_ch.right_x;
    end
  end

  // square-root stages: floor(sqrt(2^28 - rz^2)), one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (28 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = sq_res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_n_r[k] >= trial) begin
          sq_n_r[k+1] <= sq_n_r[k] - trial;
          sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BIT;
        end else begin
          sq_n_r[k+1] <= sq_n_r[k];
          sq_res_r[k+1] <= sq_res_r[k] >> 1;
        end
        sa_y_r[k+1] <= sa_y_r[k]; sa_x_r[k+1] <= sa_x_r[k];
        sb_y_r[k+1] <= sb_y_r[k]; sb_x_r[k+1] <= sb_x_r[k];
        sr_z_r[k+1] <= sr_z_r[k]; sg_r[k+1] <= sg_r[k];
      end
    end
  end

  // CORDIC setup: scale by 2^8, fold the left half-plane by pi
  function automatic cord_t setup(input logic signed [16:0] y, input logic signed [16:0] x);
    cord_t c;
    logic signed [XY_W-1:0] xs, ys;
    begin
      xs = XY_W'(x) <<< 8;
      ys = XY_W'(y) <<< 8;
      c.zero = (x == 17'sd0) && (y == 17'sd0);
      c.z = '0;
      c.x = xs;
      c.y = ys;
      if (x < 17'sd0) begin
        c.z = (y >= 17'sd0) ? PI_Q24 : -PI_Q24;
        c.x = -xs;
        c.y = -ys;
      end
      return c;
    end
  endfunction

  function automatic cord_t rot(input cord_t c, input int i);
    cord_t o;
    begin
      o = c;
      if (c.y > 0) begin
        o.x = c.x + (c.y >>> i);
        o.y = c.y - (c.x >>> i);
        o.z = c.z + atan_q24(i);
      end else begin
        o.x = c.x - (c.y >>> i);
        o.y = c.y + (c.x >>> i);
        o.z = c.z - atan_q24(i);
      end
      return o;
    end
  endfunction

  cord_t ca_r [CORDIC_STEPS+1], cb_r [CORDIC_STEPS+1], cy_r [CORDIC_STEPS+1];
  logic [1:0] cg_r [CORDIC_STEPS+1];
  logic signed [15:0] ys_in;
  assign ys_in = sr_z_r[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_r[0] <= setup(sa_y_r[SQRT_STEPS], 17'(sa_x_r[SQRT_STEPS]));
      cb_r[0] <= setup(sb_y_r[SQRT_STEPS], 17'(sb_x_r[SQRT_STEPS]));
      cy_r[0] <= setup(17'(ys_in), 17'(sq_res_r[SQRT_STEPS][15:0]));
      cg_r[0] <= sg_r[SQRT_STEPS];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
    always_ff @(posedge clk) begin
      if (adv) begin
        ca_r[i+1] <= rot(ca_r[i], i);
        cb_r[i+1] <= rot(cb_r[i], i);
        cy_r[i+1] <= rot(cy_r[i], i);
        cg_r[i+1] <= cg_r[i];
      end
    end
  end

  // output register: rounding, saturation, gimbal selection
  logic signed [15:0] qa, qb, qy;
  logic [1:0] g;
  assign qa = to_q13(ca_r[CORDIC_STEPS].z, ca_r[CORDIC_STEPS].zero, PI_Q13);
  assign qb = to_q13(cb_r[CORDIC_STEPS].z, cb_r[CORDIC_STEPS].zero, PI_Q13);
  assign qy = to_q13(cy_r[CORDIC_STEPS].z, cy_r[CORDIC_STEPS].zero, HALF_PI_Q13);
  assign g = cg_r[CORDIC_STEPS];

  logic signed [15:0] ox_r, oz_r;
  logic signed [14:0] oy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (g[1]) begin
        ox_r <= qa; oy_r <= HALF_PI_Q13[14:0]; oz_r <= '0;
      end else if (g[0]) begin
        ox_r <= -qa; oy_r <= -HALF_PI_Q13[14:0]; oz_r <= '0;
      end else begin
        ox_r <= qa; oy_r <= qy[14:0]; oz_r <= qb;
      end
    end
  end

  assign out_ch.valid = vld_r[NS-1];
  assign out_ch.angle_x = ox_r;
  assign out_ch.angle_y = oy_r;
  assign out_ch.angle_z = oz_r;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for rotation_matrix_to_euler_xyz: directed table plus random matrices,
// each result word checked against a fixed-point CORDIC angle predictor.
// Depends on rmeul_pkg, the channel interfaces in rmeul_if.sv and the top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
  import rmeul_pkg::*;
;

  localparam int N_RANDOM = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam longint PI_FINE = 52707179;
  localparam longint PI_RAD = 25736;
  localparam longint HALF_PI_RAD = 12868;
  localparam longint UNIT = 16384;

  typedef struct {
    logic signed [15:0] right_x, right_y, right_z, fwd_x, fwd_y, fwd_z, up_z;
  } matrix_t;

  typedef struct {
    logic signed [15:0] angle_x;
    logic signed [14:0] angle_y;
    logic signed [15:0] angle_z;
  } euler_t;

  typedef struct {
    matrix_t m;
    bit      typed;
    euler_t  e;
  } stim_row_t;

  // arctangent table, units of 2^-24 rad
  localparam longint ARCTAN_FINE [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst_n;

  rmeul_in_if  in_ch ();
  rmeul_out_if out_ch ();

  rotation_matrix_to_euler_xyz DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  euler_t angles_pending[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     calm = 1'b0;      // no idling on either side
  bit     hold_go = 1'b0;
  bit     hold_used = 1'b0;
  int     hold_cnt = 0;

  // vectoring CORDIC atan2, Q2.14 operands, Q3.13 result saturated to +-pi
  function automatic longint atan2_rad(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      z = (y >= 0) ? PI_FINE : -PI_FINE;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARCTAN_FINE[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN_FINE[i];
      end
    end
    z = (z + 1024) >>> 11;
    if (z > PI_RAD) z = PI_RAD;
    if (z < -PI_RAD) z = -PI_RAD;
    return z;
  endfunction

  function automatic longint cosine_of(longint s);
    longint n, root, b;
    n = (64'sd1 <<< 28) - s * s;
    root = 0;
    b = 64'sd1 <<< 30;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    return root;
  endfunction

  function automatic euler_t euler_of(matrix_t m);
    euler_t e;
    longint ay;
    if (m.right_z >= UNIT) begin
      e.angle_x = 16'(atan2_rad(m.fwd_x, m.fwd_y));
      e.angle_y = 15'(HALF_PI_RAD);
      e.angle_z = '0;
    end else if (m.right_z <= -UNIT) begin
      e.angle_x = 16'(-atan2_rad(m.fwd_x, m.fwd_y));
      e.angle_y = 15'(-HALF_PI_RAD);
      e.angle_z = '0;
    end else begin
      e.angle_x = 16'(atan2_rad(-longint'(m.fwd_z), m.up_z));
      ay = atan2_rad(m.right_z, cosine_of(m.right_z));
      if (ay > HALF_PI_RAD) ay = HALF_PI_RAD;
      if (ay < -HALF_PI_RAD) ay = -HALF_PI_RAD;
      e.angle_y = 15'(ay);
      e.angle_z = 16'(atan2_rad(-longint'(m.right_y), m.right_x));
    end
    return e;
  endfunction

  function automatic matrix_t mat(int rx, int ry, int rz, int fx, int fy, int fz, int uz);
    matrix_t m;
    m.right_x = 16'(rx); m.right_y = 16'(ry); m.right_z = 16'(rz);
    m.fwd_x = 16'(fx); m.fwd_y = 16'(fy); m.fwd_z = 16'(fz); m.up_z = 16'(uz);
    return m;
  endfunction

  function automatic logic signed [15:0] pick_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32768) - 16384);
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int mode, sel;
    mode = ($urandom_range(99) < 15) ? 0 : (($urandom_range(99) < 20) ? 2 : 1);
    m.right_x = pick_elem(mode); m.right_y = pick_elem(mode);
    m.fwd_x = pick_elem(mode); m.fwd_y = pick_elem(mode);
    m.fwd_z = pick_elem(mode); m.up_z = pick_elem(mode);
    sel = $urandom_range(99);
    // mostly normal case, with gimbal and near-gimbal edges mixed in
    if (sel < 8) m.right_z = 16'sd16384;
    else if (sel < 16) m.right_z = -16'sd16384;
    else if (sel < 22) m.right_z = 16'(16384 + $urandom_range(16383));
    else if (sel < 28) m.right_z = 16'(-16384 - $urandom_range(16384));
    else if (sel < 34) m.right_z = 16'($urandom_range(1) ? 16383 - $urandom_range(8)
                                                        : -16383 + $urandom_range(8));
    else m.right_z = 16'($urandom_range(32766) - 16383);
    return m;
  endfunction

  // sender: one matrix word, with random idle cycles ahead of it
  task automatic send_matrix(matrix_t m);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.right_x <= m.right_x; in_ch.right_y <= m.right_y; in_ch.right_z <= m.right_z;
    in_ch.fwd_x <= m.fwd_x; in_ch.fwd_y <= m.fwd_y; in_ch.fwd_z <= m.fwd_z;
    in_ch.up_z <= m.up_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // receiver ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // predict at input acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      angles_pending.push_back(euler_of(mat(in_ch.right_x, in_ch.right_y, in_ch.right_z,
          in_ch.fwd_x, in_ch.fwd_y, in_ch.fwd_z, in_ch.up_z)));
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    euler_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (angles_pending.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                 out_ch.angle_x, out_ch.angle_y, out_ch.angle_z);
        fail_count++;
      end else begin
        want = angles_pending.pop_front();
        if (out_ch.angle_x !== want.angle_x) begin
          $display("%0t: angle_x expected %0d actual %0d", $time, want.angle_x, out_ch.angle_x);
          fail_count++;
        end
        if (out_ch.angle_y !== want.angle_y) begin
          $display("%0t: angle_y expected %0d actual %0d", $time, want.angle_y, out_ch.angle_y);
          fail_count++;
        end
        if (out_ch.angle_z !== want.angle_z) begin
          $display("%0t: angle_z expected %0d actual %0d", $time, want.angle_z, out_ch.angle_z);
          fail_count++;
        end
      end
    end
  end

  // typed rows must also agree with the predictor
  task automatic check_row(stim_row_t r);
    euler_t p;
    p = euler_of(r.m);
    if (r.typed && (p.angle_x !== r.e.angle_x || p.angle_y !== r.e.angle_y ||
                    p.angle_z !== r.e.angle_z)) begin
      $display("%0t: table row expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
               r.e.angle_x, r.e.angle_y, r.e.angle_z, p.angle_x, p.angle_y, p.angle_z);
      fail_count++;
    end
  endtask

  // timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    rows.push_back('{mat(16384, 0, 0, 0, 16384, 0, 16384), 1'b1, '{16'sd0, 15'sd0, 16'sd0}});
    rows.push_back('{mat(0, 0, 16384, 0, 16384, 0, 0), 1'b1, '{16'sd0, 15'sd12868, 16'sd0}});
    rows.push_back('{mat(0, 0, -16384, 0, 16384, 0, 0), 1'b1, '{16'sd0, -15'sd12868, 16'sd0}});
    rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0), 1'b1, '{16'sd0, 15'sd0, 16'sd0}});
    rows.push_back('{mat(-16384, 0, 16383, 0, 0, 0, -16384), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(-16384, -1, -16383, 0, 0, 1, -16384), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(-16384, 1, 1, 0, 0, -1, -16384), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(0, 16384, 0, 0, 0, 16384, 0), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(0, 0, 16384, 16384, -16384, 0, 0), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(0, 0, -16384, -16384, -1, 0, 0), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(0, 0, 32767, 32767, 32767, 0, 0), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(0, 0, -32768, -32768, -32768, 0, 0), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(32767, 32767, 8192, 32767, 32767, 32767, 32767), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(-32768, -32768, -8192, -32768, -32768, -32768, -32768), 1'b0,
                     '{0, 0, 0}});
    rows.push_back('{mat(11585, -11585, 11585, 1, 2, -11585, 11585), 1'b0, '{0, 0, 0}});
    rows.push_back('{mat(1, 0, -11585, 0, 1, 0, -1), 1'b0, '{0, 0, 0}});

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.right_x <= '0; in_ch.right_y <= '0; in_ch.right_z <= '0;
    in_ch.fwd_x <= '0; in_ch.fwd_y <= '0; in_ch.fwd_z <= '0; in_ch.up_z <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      check_row(rows[i]);
      send_matrix(rows[i].m);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 400 && n < 600);
      if (n == 700) hold_go = 1'b1;
      if (n == 900) begin
        // sender pause until the pipe has drained
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (angles_pending.size() != 0) @(posedge clk);
      end
      send_matrix(random_matrix());
    end
    in_ch.valid <= 1'b0;

    while (angles_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
